/* design/srg_pkg.sv */
// shared types and constants for the stepper trapezoid ramp generator
package srg_pkg;

   // width of the step counter, 8 to 32
   localparam int STEP_BITS = 32;

   localparam int PERIOD_BITS  = 8;
   localparam int WINDOW_BITS  = 16;
   localparam int COUNT_BITS   = 32;
   localparam int CSR_ADDR_BITS = 1;
   localparam int CSR_DATA_BITS = 16;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 48;

   localparam logic [PERIOD_BITS-1:0] SLOWEST_RESET = 8'd30;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET  = 16'd3000;
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET  = 8'd20;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_SLOWEST_PERIOD = 1'b0,
      CSR_DECEL_WINDOW   = 1'b1
   } csr_addr_type;

   typedef enum logic [2:0] {
      ACT_FAST_TICK = 3'd0,
      ACT_RAMP_TICK = 3'd1,
      ACT_GO        = 3'd2,
      ACT_ESTOP     = 3'd3,
      ACT_SOFT_STOP = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      MODE_HOLD  = 2'd0,
      MODE_ACCEL = 2'd1,
      MODE_DECEL = 2'd2
   } ramp_mode_type;

   typedef struct packed {
      logic [2:0]            action;
      logic                  direction;
      logic [COUNT_BITS-1:0] step_total;
   } req_item_type;

   typedef struct packed {
      logic [PERIOD_BITS-1:0] current_period;
      logic [COUNT_BITS-1:0]  steps_left;
      logic                   stop_flag;
      logic                   motor_enable;
      logic                   dir_positive;
      logic                   step_pulse;
   } rsp_item_type;

endpackage

/* design/srg_in_reg.sv */
// input holding register for one request transfer
module srg_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  srg_pkg::req_item_type in_item,
   output logic                  in_ready,
   input  logic                  take,
   output logic                  held_valid,
   output srg_pkg::req_item_type held_item
);

   logic                  valid_ff;
   logic                  valid_in;
   srg_pkg::req_item_type item_ff;

   assign in_ready   = !valid_ff || take;
   assign held_valid = valid_ff;
   assign held_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule

/* design/srg_engine.sv */
// motion state registers and the per-event update logic
module srg_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 fire,
   input  srg_pkg::req_item_type                item,
   input  logic [srg_pkg::PERIOD_BITS-1:0]      slowest_period,
   input  logic [srg_pkg::WINDOW_BITS-1:0]      decel_window,
   output srg_pkg::rsp_item_type                result
);

   logic [srg_pkg::STEP_BITS-1:0]   remaining_ff, remaining_in;
   logic [srg_pkg::PERIOD_BITS-1:0] countdown_ff, countdown_in;
   logic [srg_pkg::PERIOD_BITS-1:0] period_ff, period_in;
   srg_pkg::ramp_mode_type          mode_ff, mode_in;
   logic                            stop_ff, stop_in;
   logic                            dir_ff, dir_in;
   logic                            drivers_ff, drivers_in;
   logic                            pulse;

   logic [srg_pkg::PERIOD_BITS-1:0] slowest_eff;
   logic [srg_pkg::COUNT_BITS-1:0]  remaining_wide;
   logic [srg_pkg::COUNT_BITS-1:0]  window_wide;
   logic                            below_window;

   // zero slowest period acts as one
   assign slowest_eff    = (slowest_period == '0) ? srg_pkg::PERIOD_BITS'(1) : slowest_period;
   assign remaining_wide = srg_pkg::COUNT_BITS'(remaining_ff);
   assign window_wide    = srg_pkg::COUNT_BITS'(decel_window);
   assign below_window   = remaining_wide < window_wide;

   always_comb begin
      remaining_in = remaining_ff;
      countdown_in = countdown_ff;
      period_in    = period_ff;
      mode_in      = mode_ff;
      stop_in      = stop_ff;
      dir_in       = dir_ff;
      drivers_in   = drivers_ff;
      pulse        = 1'b0;
      unique case (srg_pkg::action_type'(item.action))
         srg_pkg::ACT_FAST_TICK: begin
            if (countdown_ff != '0) begin
               countdown_in = countdown_ff - 1'b1;
            end else begin
               countdown_in = period_ff;
               if (remaining_ff == srg_pkg::STEP_BITS'(1)) begin
                  stop_in = 1'b1;
               end
               if (remaining_ff != '0) begin
                  remaining_in = remaining_ff - 1'b1;
                  pulse        = 1'b1;
               end
            end
         end
         srg_pkg::ACT_RAMP_TICK: begin
            if (remaining_ff == '0) begin
               drivers_in = 1'b0;
            end
            if (below_window) begin
               mode_in = srg_pkg::MODE_DECEL;
            end
            if (mode_in == srg_pkg::MODE_ACCEL) begin
               if (period_ff > srg_pkg::PERIOD_BITS'(1)) begin
                  period_in = period_ff - 1'b1;
               end else begin
                  mode_in   = srg_pkg::MODE_HOLD;
                  period_in = srg_pkg::PERIOD_BITS'(1);
               end
            end
            if (mode_in == srg_pkg::MODE_DECEL) begin
               if (period_ff < slowest_eff) begin
                  period_in = period_ff + 1'b1;
               end
            end
         end
         srg_pkg::ACT_GO: begin
            dir_in       = item.direction;
            remaining_in = item.step_total[srg_pkg::STEP_BITS-1:0];
            countdown_in = '0;
            period_in    = slowest_eff;
            mode_in      = srg_pkg::MODE_ACCEL;
            stop_in      = 1'b0;
            drivers_in   = 1'b1;
         end
         srg_pkg::ACT_ESTOP: begin
            remaining_in = '0;
            mode_in      = srg_pkg::MODE_HOLD;
            stop_in      = 1'b1;
         end
         srg_pkg::ACT_SOFT_STOP: begin
            if (remaining_wide > window_wide) begin
               remaining_in = srg_pkg::STEP_BITS'(decel_window);
            end
         end
         default: begin
         end
      endcase
   end

   assign result.step_pulse     = pulse;
   assign result.dir_positive   = dir_in;
   assign result.motor_enable   = drivers_in;
   assign result.stop_flag      = stop_in;
   assign result.steps_left     = srg_pkg::COUNT_BITS'(remaining_in);
   assign result.current_period = period_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         countdown_ff <= '0;
         period_ff    <= srg_pkg::PERIOD_RESET;
         mode_ff      <= srg_pkg::MODE_HOLD;
         stop_ff      <= 1'b0;
         dir_ff       <= 1'b0;
         drivers_ff   <= 1'b1;
      end else if (fire) begin
         remaining_ff <= remaining_in;
         countdown_ff <= countdown_in;
         period_ff    <= period_in;
         mode_ff      <= mode_in;
         stop_ff      <= stop_in;
         dir_ff       <= dir_in;
         drivers_ff   <= drivers_in;
      end
   end

endmodule

/* design/stepper_trapezoid_ramp_generator_core.sv */
// top level of the stepper pulse generator with trapezoidal ramp
//
// every request transfer carries one event (fast tick, ramp tick, go,
// emergency stop or soft stop) and yields exactly one response transfer with
// the status after that event. an event is taken every cycle while the
// response side does not stall: the request sits in the input register, the
// motion state registers update as it moves on, and the status lands in the
// response register, so the throughput is one transfer per cycle while
// responses are taken. the input register refills while a finished response
// still waits, so a stalled response side costs at most the one extra slot.
// configuration writes go through the csr port and take effect on the next
// event; write them only while no event is in flight.
module stepper_trapezoid_ramp_generator_core (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] direction, [32:1] step_total, [39:33] zero
   input  logic [srg_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // [2:0] action
   input  logic [2:0]                          req_tuser,
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] step_pulse, [1] dir_positive, [2] motor_enable, [3] stop_flag,
   // [35:4] steps_left, [43:36] current_period, [47:44] zero
   output logic [srg_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // configuration write port
   input  logic                                csr_we,
   input  logic [srg_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [srg_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   // configuration registers
   logic [srg_pkg::PERIOD_BITS-1:0] slowest_ff;
   logic [srg_pkg::WINDOW_BITS-1:0] window_ff;

   // request path
   srg_pkg::req_item_type req_item;
   srg_pkg::req_item_type held_item;
   logic                  held_valid;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   srg_pkg::rsp_item_type rsp_item_ff;
   srg_pkg::rsp_item_type result;

   logic out_free;
   logic fire;

   assign req_item.action     = req_tuser;
   assign req_item.direction  = req_tdata[0];
   assign req_item.step_total = req_tdata[srg_pkg::COUNT_BITS:1];

   // held event moves on when the response slot is empty or being drained
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign fire     = held_valid && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         slowest_ff <= srg_pkg::SLOWEST_RESET;
         window_ff  <= srg_pkg::WINDOW_RESET;
      end else if (csr_we) begin
         unique case (srg_pkg::csr_addr_type'(csr_addr))
            srg_pkg::CSR_SLOWEST_PERIOD: slowest_ff <= csr_wdata[srg_pkg::PERIOD_BITS-1:0];
            srg_pkg::CSR_DECEL_WINDOW:   window_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   srg_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_item    (req_item),
      .in_ready   (req_tready),
      .take       (out_free),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   srg_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .item           (held_item),
      .slowest_period (slowest_ff),
      .decel_window   (window_ff),
      .result         (result)
   );

   // response slot: loads on fire, empties on a transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = held_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = srg_pkg::RSP_DATA_BITS'(rsp_item_ff);

endmodule

/* bench/tb_top.sv */
// testbench for the stepper trapezoid ramp generator: directed and random events
`timescale 1ns / 100ps

module tb_top;
   import srg_pkg::*;

   // unused action codes, the block must leave its state alone on these
   localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;
   localparam logic [COUNT_BITS-1:0] STEP_MASK = {COUNT_BITS{1'b1}} >> (COUNT_BITS - STEP_BITS);
   // covers the input and response registers, a little margin on top
   localparam int DRAIN_CYCLES = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [2:0]               req_tuser  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_we    = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr  = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   stepper_trapezoid_ramp_generator_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow copy of the motion state and registers
   logic [PERIOD_BITS-1:0] slowest_cfg;
   logic [WINDOW_BITS-1:0] window_cfg;
   logic [COUNT_BITS-1:0]  steps_q;
   logic [PERIOD_BITS-1:0] countdown_q;
   logic [PERIOD_BITS-1:0] period_q;
   ramp_mode_type          mode_q;
   logic                   stop_q;
   logic                   dir_q;
   logic                   enable_q;

   // status words still owed by the block, oldest first
   rsp_item_type expected_status[$];
   int  mismatch_count = 0;
   // when set, neither side inserts gaps or stalls
   bit  steady = 1'b0;
   int  stall_left = 0;

   task automatic reset_motion_model();
      slowest_cfg = SLOWEST_RESET;
      window_cfg  = WINDOW_RESET;
      steps_q     = '0;
      countdown_q = '0;
      period_q    = PERIOD_RESET;
      mode_q      = MODE_HOLD;
      stop_q      = 1'b0;
      dir_q       = 1'b0;
      enable_q    = 1'b1;
   endtask

   // advance the shadow state by one event and return the status it should produce
   function automatic rsp_item_type next_status(input logic [2:0] act, input logic dir,
                                                input logic [COUNT_BITS-1:0] total);
      rsp_item_type           res;
      logic                   pulse;
      logic [PERIOD_BITS-1:0] slowest_eff;
      pulse       = 1'b0;
      // zero slowest period counts as one
      slowest_eff = (slowest_cfg == '0) ? 8'd1 : slowest_cfg;
      case (act)
         ACT_FAST_TICK: begin
            if (countdown_q != '0) begin
               countdown_q = countdown_q - 1'b1;
            end else begin
               countdown_q = period_q;
               if (steps_q == 1) stop_q = 1'b1;
               if (steps_q != '0) begin
                  steps_q = steps_q - 1'b1;
                  pulse   = 1'b1;
               end
            end
         end
         ACT_RAMP_TICK: begin
            if (steps_q == '0) enable_q = 1'b0;
            if (steps_q < {16'd0, window_cfg}) mode_q = MODE_DECEL;
            if (mode_q == MODE_ACCEL) begin
               if (period_q > 1) begin
                  period_q = period_q - 1'b1;
               end else begin
                  mode_q   = MODE_HOLD;
                  period_q = 8'd1;
               end
            end
            if (mode_q == MODE_DECEL && period_q < slowest_eff) period_q = period_q + 1'b1;
         end
         ACT_GO: begin
            dir_q       = dir;
            steps_q     = total & STEP_MASK;
            countdown_q = '0;
            period_q    = slowest_eff;
            mode_q      = MODE_ACCEL;
            stop_q      = 1'b0;
            enable_q    = 1'b1;
         end
         ACT_ESTOP: begin
            steps_q = '0;
            mode_q  = MODE_HOLD;
            stop_q  = 1'b1;
         end
         ACT_SOFT_STOP: begin
            if (steps_q > {16'd0, window_cfg}) steps_q = {16'd0, window_cfg};
         end
         default: begin
         end
      endcase
      res.step_pulse     = pulse;
      res.dir_positive   = dir_q;
      res.motor_enable   = enable_q;
      res.stop_flag      = stop_q;
      res.steps_left     = steps_q;
      res.current_period = period_q;
      return res;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // one event transfer; called right after a rising edge
   task automatic send_event(input logic [2:0] act, input logic dir,
                             input logic [COUNT_BITS-1:0] total);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {{(REQ_DATA_BITS-COUNT_BITS-1){1'b0}}, total, dir};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_status.push_back(next_status(act, dir, total));
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // let every owed status come back, then give the pipeline time to empty
   task automatic drain_events();
      req_tvalid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write while idle, shadow copy follows at the same edge
   task automatic write_register(input csr_addr_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SLOWEST_PERIOD) slowest_cfg = value[PERIOD_BITS-1:0];
      else window_cfg = value[WINDOW_BITS-1:0];
   endtask

   // response side: random stalls and comparison against the oldest owed status
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got = rsp_item_type'(rsp_tdata[$bits(rsp_item_type)-1:0]);
         if (expected_status.size() == 0) begin
            $display("%0t: unexpected status transfer, actual %h", $time, got);
            mismatch_count++;
         end else begin
            want = expected_status.pop_front();
            if (got.step_pulse !== want.step_pulse) begin
               $display("%0t: step_pulse expected %0d actual %0d",
                        $time, want.step_pulse, got.step_pulse);
               mismatch_count++;
            end
            if (got.dir_positive !== want.dir_positive) begin
               $display("%0t: dir_positive expected %0d actual %0d",
                        $time, want.dir_positive, got.dir_positive);
               mismatch_count++;
            end
            if (got.motor_enable !== want.motor_enable) begin
               $display("%0t: motor_enable expected %0d actual %0d",
                        $time, want.motor_enable, got.motor_enable);
               mismatch_count++;
            end
            if (got.stop_flag !== want.stop_flag) begin
               $display("%0t: stop_flag expected %0d actual %0d",
                        $time, want.stop_flag, got.stop_flag);
               mismatch_count++;
            end
            if (got.steps_left !== want.steps_left) begin
               $display("%0t: steps_left expected %0d actual %0d",
                        $time, want.steps_left, got.steps_left);
               mismatch_count++;
            end
            if (got.current_period !== want.current_period) begin
               $display("%0t: current_period expected %0d actual %0d",
                        $time, want.current_period, got.current_period);
               mismatch_count++;
            end
         end
      end
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
   end

   // events with no move loaded, reset register values
   task automatic test_idle_events();
      logic [2:0] act;
      send_event(ACT_FAST_TICK, 1'b1, $urandom);
      // no steps left: drivers go off and the period creeps up toward slowest
      send_event(ACT_RAMP_TICK, 1'b1, $urandom);
      send_event(ACT_SOFT_STOP, 1'b0, $urandom);
      send_event(ACT_ESTOP, 1'b1, $urandom);
      for (act = ACT_UNUSED_FIRST; act != ACT_UNUSED_FIRST - 3'd1; act++) begin
         send_event(act, 1'b1, 32'hFFFF_FFFF);
         if (act == ACT_UNUSED_LAST) break;
      end
      drain_events();
   endtask

   // short hand-built moves over the register extremes
   task automatic test_directed_moves();
      // full-range count, soft stop clamps it to the window
      send_event(ACT_GO, 1'b1, 32'hFFFF_FFFF);
      send_event(ACT_SOFT_STOP, 1'b0, '0);
      send_event(ACT_FAST_TICK, 1'b0, '0);
      send_event(ACT_RAMP_TICK, 1'b0, '0);
      send_event(ACT_ESTOP, 1'b0, '0);
      drain_events();
      // no deceleration window: ramp down to period one, then hold, then finish
      write_register(CSR_DECEL_WINDOW, 16'd0);
      write_register(CSR_SLOWEST_PERIOD, 16'd3);
      send_event(ACT_GO, 1'b0, 32'd2);
      repeat (3) send_event(ACT_RAMP_TICK, 1'b1, '0);
      repeat (3) send_event(ACT_FAST_TICK, 1'b1, '0);
      send_event(ACT_RAMP_TICK, 1'b1, '0);
      drain_events();
      // zero slowest period, upper data bits set and ignored
      write_register(CSR_SLOWEST_PERIOD, 16'hFF00);
      send_event(ACT_GO, 1'b1, '0);
      send_event(ACT_RAMP_TICK, 1'b0, '0);
      drain_events();
      write_register(CSR_SLOWEST_PERIOD, 16'd255);
      write_register(CSR_DECEL_WINDOW, 16'hFFFF);
      send_event(ACT_GO, 1'b1, 32'h0001_0000);
      send_event(ACT_SOFT_STOP, 1'b1, '0);
      drain_events();
   endtask

   // random phases, each with its own register setting; mostly complete moves
   task automatic test_random_moves(input int phases, input int per_phase);
      logic [2:0]            act;
      logic                  dir;
      logic [COUNT_BITS-1:0] total;
      logic [PERIOD_BITS-1:0] slow;
      logic [WINDOW_BITS-1:0] window;
      int r;
      for (int p = 0; p < phases; p++) begin
         case (p)
            0: begin slow = 8'd1;   window = 16'd0;     end
            1: begin slow = 8'd255; window = 16'hFFFF;  end
            2: begin slow = 8'd0;   window = 16'd20;    end
            default: begin
               r      = $urandom_range(0, 3);
               slow   = (r == 0) ? 8'd255 : 8'($urandom_range(1, 40));
               r      = $urandom_range(0, 3);
               window = (r == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
            end
         endcase
         write_register(CSR_SLOWEST_PERIOD, {8'($urandom), slow});
         write_register(CSR_DECEL_WINDOW, window);
         steady = (p % 4 == 3);
         for (int i = 0; i < per_phase; i++) begin
            r     = $urandom_range(0, 99);
            dir   = 1'($urandom);
            total = $urandom;
            if ((steps_q == '0 && $urandom_range(0, 2) == 0) || r >= 98 || (r >= 82 && r < 88)) begin
               act = ACT_GO;
               r   = $urandom_range(0, 9);
               // slow settings get tiny moves so they still finish
               if (slowest_cfg > 100 && r < 8) total = $urandom_range(1, 4);
               else if (r < 8) total = $urandom_range(1, 40);
               else if (r == 8) total = $urandom_range(0, 5000);
            end else if (r < 68) act = ACT_FAST_TICK;
            else if (r < 82) act = ACT_RAMP_TICK;
            else if (r < 92) act = ACT_SOFT_STOP;
            else if (r < 95) act = ACT_ESTOP;
            else act = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
            send_event(act, dir, total);
         end
         drain_events();
      end
      steady = 1'b0;
   endtask

   initial begin
      reset_motion_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_events();
      test_directed_moves();
      test_random_moves(10, 190);
      if (mismatch_count == 0) begin
         $display("stepper_trapezoid_ramp_generator_core: match");
      end else begin
         $display("stepper_trapezoid_ramp_generator_core: mismatch");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #8_000_000;
      $display("stepper_trapezoid_ramp_generator_core: mismatch");
      $finish;
   end

endmodule
